>>> src/code_to_index_map_lookup_macros.svh
// Assertion macros used by the code-to-index map lookup checker.
`ifndef CODE_TO_INDEX_MAP_LOOKUP_MACROS_SVH
`define CODE_TO_INDEX_MAP_LOOKUP_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define CIMAP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define CIMAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/cimap_pkg.sv
// Types and constants of the code-to-index map lookup.
`default_nettype none

package cimap_pkg;

   // Map schemes selected by the map_kind register
   localparam logic [1:0] KIND_OFFSET = 2'd0;
   localparam logic [1:0] KIND_DIRECT = 2'd1;
   localparam logic [1:0] KIND_PAIRS  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // Request word modes
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // Configuration register indexes
   localparam logic CSR_BASE_CODE = 1'b0;
   localparam logic CSR_MAP_KIND  = 1'b1;

   // Index returned on a miss
   localparam logic [15:0] MISS_INDEX = 16'hffff;

   // Configuration seen by the sequencer
   typedef struct packed {
      logic [15:0] base_code;
      logic [1:0]  map_kind;
   } cimap_cfg_type;

   // Lookup sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR_RD,
      ST_HDR,
      ST_DIR_RD,
      ST_DIR,
      ST_PROBE,
      ST_KEY,
      ST_VAL_RD,
      ST_VAL,
      ST_DONE
   } cimap_state_type;

endpackage

`default_nettype wire

>>> src/cimap_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module cimap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-first: the read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/cimap_ctrl.sv
// Lookup sequencer: store port control, binary search unit and result register.
`default_nettype none

module cimap_ctrl #(
   parameter int STORE_WORDS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request words
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic [9:0]                     req_word_addr,
   input  wire logic [15:0]                    req_word_data,
   input  wire logic [15:0]                    req_code,
   // configuration
   input  wire cimap_pkg::cimap_cfg_type       cfg,
   // store port
   output logic                                ram_we,
   output logic [$clog2(STORE_WORDS)-1:0]      ram_addr,
   output logic [15:0]                         ram_wdata,
   input  wire logic [15:0]                    ram_rdata,
   // response words
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [15:0]                         rsp_index_out,
   output logic                                rsp_hit
);

   localparam int AW       = $clog2(STORE_WORDS);
   localparam int PAIR_CAP = (STORE_WORDS - 1) / 2;
   localparam int CW       = $clog2(PAIR_CAP + 1);

   cimap_pkg::cimap_state_type state_ff, state_in;

   logic [15:0]   code_ff, code_in;
   logic [15:0]   diff_ff, diff_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [15:0]   res_index_ff, res_index_in;
   logic          res_hit_ff, res_hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_index_ff, rsp_index_in;
   logic          rsp_hit_ff, rsp_hit_in;

   logic          req_take;
   logic          lookup_take;
   logic [16:0]   wr_addr_wide;
   logic          wr_ok;
   logic [16:0]   diff_wide;
   logic          dir_ok;
   logic [CW-1:0] count_sat;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid;
   logic [16:0]   key_addr_wide;
   logic [16:0]   val_addr_wide;
   logic          key_lt;
   logic          key_eq;
   logic [CW-1:0] lo_step;
   logic [CW-1:0] hi_step;
   logic          more;
   logic          out_free;

   // Request handshake: words are taken only between lookups
   assign req_stall   = (state_ff != cimap_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign lookup_take = req_take && (req_mode == cimap_pkg::MODE_LOOKUP);

   // Store writes beyond the store are dropped
   assign wr_addr_wide = 17'(req_word_addr);
   assign wr_ok        = (wr_addr_wide < 17'(STORE_WORDS));

   // Code offset from the map base; direct table bound check
   assign diff_wide = {1'b0, req_code} - {1'b0, cfg.base_code};
   assign dir_ok    = !diff_wide[16] && ({1'b0, diff_wide[15:0]} < 17'(STORE_WORDS));

   // Pair count from the header, saturated to the pair capacity of the store
   assign count_sat = (ram_rdata > 16'(PAIR_CAP)) ? CW'(PAIR_CAP) : ram_rdata[CW-1:0];

   // Probe point: floor((lo + hi_last) / 2) with hi kept exclusive
   assign mid_sum       = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CW{1'b0}}, 1'b1};
   assign mid           = mid_sum[CW:1];
   assign key_addr_wide = 17'({mid, 1'b1});
   assign val_addr_wide = 17'({mid_ff, 1'b0}) + 17'd2;

   // Shared compare unit: key against code, then narrow the window
   assign key_lt  = (ram_rdata < code_ff);
   assign key_eq  = (ram_rdata == code_ff);
   assign lo_step = key_lt ? (mid_ff + {{(CW-1){1'b0}}, 1'b1}) : lo_ff;
   assign hi_step = key_lt ? hi_ff : mid_ff;
   assign more    = (lo_step < hi_step);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cimap_pkg::ST_IDLE: begin
            if (lookup_take) begin
               unique case (cfg.map_kind) inside
                  cimap_pkg::KIND_OFFSET, cimap_pkg::KIND_PAIRS: begin
                     state_in = cimap_pkg::ST_HDR_RD;
                  end
                  cimap_pkg::KIND_DIRECT: begin
                     state_in = dir_ok ? cimap_pkg::ST_DIR_RD : cimap_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = cimap_pkg::ST_DONE;
                  end
               endcase
            end
         end
         cimap_pkg::ST_HDR_RD: begin
            state_in = cimap_pkg::ST_HDR;
         end
         cimap_pkg::ST_HDR: begin
            if (cfg.map_kind == cimap_pkg::KIND_OFFSET || count_sat == '0) begin
               state_in = cimap_pkg::ST_DONE;
            end else begin
               state_in = cimap_pkg::ST_PROBE;
            end
         end
         cimap_pkg::ST_DIR_RD: begin
            state_in = cimap_pkg::ST_DIR;
         end
         cimap_pkg::ST_DIR: begin
            state_in = cimap_pkg::ST_DONE;
         end
         cimap_pkg::ST_PROBE: begin
            state_in = cimap_pkg::ST_KEY;
         end
         cimap_pkg::ST_KEY: begin
            if (key_eq) begin
               state_in = cimap_pkg::ST_VAL_RD;
            end else if (more) begin
               state_in = cimap_pkg::ST_PROBE;
            end else begin
               state_in = cimap_pkg::ST_DONE;
            end
         end
         cimap_pkg::ST_VAL_RD: begin
            state_in = cimap_pkg::ST_VAL;
         end
         cimap_pkg::ST_VAL: begin
            state_in = cimap_pkg::ST_DONE;
         end
         cimap_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cimap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cimap_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and store port per state
   always_comb begin
      code_in      = code_ff;
      diff_in      = diff_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_index_in = res_index_ff;
      res_hit_in   = res_hit_ff;
      ram_we       = 1'b0;
      ram_addr     = addr_ff;
      ram_wdata    = req_word_data;
      // a taken response drops unless a new one replaces it
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;

      unique case (state_ff)
         cimap_pkg::ST_IDLE: begin
            ram_addr = wr_addr_wide[AW-1:0];
            ram_we   = req_take && (req_mode == cimap_pkg::MODE_WRITE) && wr_ok;
            if (lookup_take) begin
               code_in      = req_code;
               diff_in      = diff_wide[15:0];
               addr_in      = (cfg.map_kind == cimap_pkg::KIND_DIRECT) ?
                              diff_wide[AW-1:0] : '0;
               res_index_in = cimap_pkg::MISS_INDEX;
               res_hit_in   = 1'b0;
            end
         end
         cimap_pkg::ST_HDR: begin
            if (cfg.map_kind == cimap_pkg::KIND_OFFSET) begin
               res_index_in = ram_rdata + diff_ff;
               res_hit_in   = 1'b1;
            end else begin
               lo_in = '0;
               hi_in = count_sat;
            end
         end
         cimap_pkg::ST_DIR, cimap_pkg::ST_VAL: begin
            res_index_in = ram_rdata;
            res_hit_in   = 1'b1;
         end
         cimap_pkg::ST_PROBE: begin
            ram_addr = key_addr_wide[AW-1:0];
            mid_in   = mid;
         end
         cimap_pkg::ST_KEY: begin
            if (key_eq) begin
               addr_in = val_addr_wide[AW-1:0];
            end else begin
               lo_in = lo_step;
               hi_in = hi_step;
            end
         end
         cimap_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_hit_in   = res_hit_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cimap_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      diff_ff      <= diff_in;
      addr_ff      <= addr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_index_ff <= res_index_in;
      res_hit_ff   <= res_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_hit       = rsp_hit_ff;

endmodule

`default_nettype wire

>>> src/code_to_index_map_lookup.sv
// Top level of the code-to-index map lookup: configuration registers, store and sequencer.
//
// Maps a 16-bit code to a 16-bit index through a store of STORE_WORDS 16-bit
// words. A request word with mode 0 writes one store word (addresses past the
// store are dropped) and returns nothing; a request word with mode 1 looks up
// a code and returns exactly one response word. Word 0 of the store is the
// header: the first index for the offset map or the pair count for the sorted
// pair search, whose keys and values sit at words 1+2p and 2+2p. Misses return
// 0xffff with hit low. Lookups run on one single-port store with a registered
// read and one shared compare unit, so the request side is stalled while a
// lookup is in progress. The pair search does one store read and one key
// compare per probe (at most 9 probes with the default 511 pairs). A finished
// response waits in an output register, so the next request word is taken
// while it is still stalled. The store has no reset; words must be written
// before a lookup reads them. Configuration must be written only while idle;
// the block itself does not enforce this.
`default_nettype none

module code_to_index_map_lookup #(
   parameter int STORE_WORDS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   // request words
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [9:0]  req_word_addr,
   input  wire logic [15:0] req_word_data,
   input  wire logic [15:0] req_code,
   // response words
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_index_out,
   output logic             rsp_hit
);

   localparam int AW = $clog2(STORE_WORDS);

   logic [15:0] base_code_ff, base_code_in;
   logic [1:0]  map_kind_ff, map_kind_in;

   cimap_pkg::cimap_cfg_type cfg;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wdata;
   logic [15:0]   ram_rdata;

   // Register write decode
   always_comb begin
      base_code_in = base_code_ff;
      map_kind_in  = map_kind_ff;
      if (csr_wen) begin
         unique case (csr_index)
            cimap_pkg::CSR_BASE_CODE: base_code_in = csr_wdata;
            cimap_pkg::CSR_MAP_KIND:  map_kind_in  = csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_code_ff <= '0;
         map_kind_ff  <= cimap_pkg::KIND_OFFSET;
      end else begin
         base_code_ff <= base_code_in;
         map_kind_ff  <= map_kind_in;
      end
   end

   assign cfg.base_code = base_code_ff;
   assign cfg.map_kind  = map_kind_ff;

   // Word store
   cimap_ram #(
      .WIDTH (16),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Lookup sequencer
   cimap_ctrl #(
      .STORE_WORDS (STORE_WORDS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_word_addr (req_word_addr),
      .req_word_data (req_word_data),
      .req_code      (req_code),
      .cfg           (cfg),
      .ram_we        (ram_we),
      .ram_addr      (ram_addr),
      .ram_wdata     (ram_wdata),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_index_out (rsp_index_out),
      .rsp_hit       (rsp_hit)
   );

endmodule

`default_nettype wire

>>> src/cimap_checker.sv
// Port-level checker for the code-to-index map lookup, bound to the top level.
`default_nettype none

`include "code_to_index_map_lookup_macros.svh"

module cimap_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_mode,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_index_out,
   input wire logic        rsp_hit
);

   logic req_take;
   logic rsp_held;

   assign req_take = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // A lookup occupies the sequencer: the next cycle stalls requests
   `CIMAP_ASSERT_NEXT(a_lookup_busy, clock, reset, req_take && req_mode == cimap_pkg::MODE_LOOKUP, req_stall, "request taken during a lookup")

   // A store write completes in its own cycle
   `CIMAP_ASSERT_NEXT(a_write_single, clock, reset, req_take && req_mode == cimap_pkg::MODE_WRITE, !req_stall, "store write held the request side")

   // A miss always carries the miss index
   `CIMAP_ASSERT_NOW(a_miss_index, clock, reset, rsp_valid && !rsp_hit, rsp_index_out == cimap_pkg::MISS_INDEX, "miss without miss index")

   // A stalled response word holds
   `CIMAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_index_out) && $stable(rsp_hit), "stalled response changed")

endmodule

bind code_to_index_map_lookup cimap_checker u_cimap_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_index_out (rsp_index_out),
   .rsp_hit       (rsp_hit)
);

`default_nettype wire
